@@ hdl/swkd_pkg.sv @@
// swkd_pkg: shared widths, register indexes and reset values for the
// sliding window keyword detector; no dependencies
package swkd_pkg;

  localparam int PROB_W    = 8;
  localparam int CUTOFF_W  = 8;
  localparam int WSIZE_W   = 5;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;
  localparam int AVG_W     = 8;

  typedef logic [PROB_W-1:0]    prob_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

  // configuration register indexes
  localparam cfg_idx_t REG_CUTOFF      = cfg_idx_t'(0);
  localparam cfg_idx_t REG_WINDOW_SIZE = cfg_idx_t'(1);

  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = CUTOFF_W'(200);
  localparam logic [WSIZE_W-1:0]  WSIZE_RST  = WSIZE_W'(5);

endpackage

@@ hdl/swkd_if.sv @@
// swkd_if: valid/ready channel interfaces for probabilities, results and
// configuration writes; depends on swkd_pkg
interface swkd_in_if;
  import swkd_pkg::*;
  logic  valid;
  logic  ready;
  prob_t probability;
  modport source (output valid, output probability, input ready);
  modport sink   (input valid, input probability, output ready);
endinterface

interface swkd_out_if;
  import swkd_pkg::*;
  logic   valid;
  logic   ready;
  logic   detected;
  logic   evaluated;
  prob_t  window_average;
  prob_t  window_peak;
  prob_t  best_average;
  total_t inference_total;
  total_t detection_total;
  modport source (output valid, output detected, output evaluated, output window_average,
                  output window_peak, output best_average, output inference_total,
                  output detection_total, input ready);
  modport sink   (input valid, input detected, input evaluated, input window_average,
                  input window_peak, input best_average, input inference_total,
                  input detection_total, output ready);
endinterface

interface swkd_cfg_if;
  import swkd_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_dat_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/swkd_ram.sv @@
// swkd_ram: generic simple dual port ram, one write and one registered read
// per cycle; no dependencies
module swkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ hdl/swkd_div.sv @@
// swkd_div: restoring divider producing an 8 bit quotient, one bit a cycle;
// the high part of the dividend must be below the divisor; depends on swkd_pkg
module swkd_div #(
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEN_W-1:0] num_hi,
  input  logic [swkd_pkg::AVG_W-1:0] num_lo,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [swkd_pkg::AVG_W-1:0] quotient
);
  import swkd_pkg::*;

  localparam int STEP_W = $clog2(AVG_W);

  logic             busy_r;
  logic             done_r;
  logic [DEN_W-1:0] rem_r;
  logic [AVG_W-1:0] lo_r;
  logic [AVG_W-1:0] q_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, lo_r[AVG_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_W'(AVG_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num_hi;
      lo_r   <= num_lo;
      q_r    <= '0;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      lo_r   <= {lo_r[AVG_W-2:0], 1'b0};
      q_r    <= {q_r[AVG_W-2:0], fits};
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

@@ hdl/sliding_window_keyword_detector.sv @@
// sliding_window_keyword_detector: top level, ring memory walk, warm-up and
// detection control; depends on swkd_pkg, swkd_if, swkd_ram, swkd_div
//
//  channel  dir  handshake      payload
//  in_chan  in   valid/ready    probability
//  out_chan out  valid/ready    detected, evaluated, averages, peak, totals
//  cfg_chan in   valid/ready    index (0 cutoff, 1 window_size), data
//
// an item that is not evaluated goes from acceptance through ST_FINISH to the
// output register once that is free; an evaluated one first passes through
// the walk of the ring through the memory read port, one entry a cycle, and
// the bit-serial divider for the average
// reset is synchronous; ring entries read as zero through per-entry valid
// bits, so no clearing pass is needed after reset or a detection
// one item is in flight at a time; a new one is taken while the previous
// result still waits in the output register; cfg writes are always taken
module sliding_window_keyword_detector #(
  parameter int WINDOW_MAX     = 16,
  parameter int WARMUP_WINDOWS = 100
) (
  input  logic              clk,
  input  logic              rst_n,
  swkd_in_if.sink           in_chan,
  swkd_out_if.source        out_chan,
  swkd_cfg_if.sink          cfg_chan
);
  import swkd_pkg::*;

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int W_W   = $clog2(WINDOW_MAX + 1);
  localparam int PW    = W_W + 1;
  localparam int SUM_W = PROB_W + W_W;
  localparam int WU_W  = (WARMUP_WINDOWS > 0) ? $clog2(WARMUP_WINDOWS + 1) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CUTOFF_W-1:0]  cutoff_r;
  logic [WSIZE_W-1:0]   wsize_r;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [WU_W-1:0]      wu_r, wu_nxt;
  logic [WINDOW_MAX-1:0] valid_r;
  logic [W_W-1:0]       w_eff, w_r;
  logic [SUM_W-1:0]     thr_r, sum_r;
  logic [PROB_W-1:0]    peak_r;
  logic [W_W-1:0]       issue_r;
  logic                 pend_r;
  logic                 pend_valid_r;
  logic                 det_r, eval_r;
  logic [PROB_W-1:0]    held_avg_r, held_peak_r, best_r;
  total_t               acc_r, hit_r;
  logic                 out_valid_r;
  logic [PW-1:0]        pos_inc;
  logic                 accept, eval_now, issue_go, div_start, div_done, out_free;
  logic [PROB_W-1:0]    rd_data, rd_entry;
  logic [AVG_W-1:0]     quotient;
  logic [IDX_W-1:0]     rd_addr;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign accept         = in_chan.valid && (state_r == ST_IDLE);
  assign out_free       = !out_valid_r || out_chan.ready;

  // a window beyond the ring depth uses the whole ring
  assign w_eff = (int'(wsize_r) > WINDOW_MAX) ? W_W'(WINDOW_MAX) : W_W'(wsize_r);

  assign pos_inc = PW'(pos_r) + PW'(1);
  assign pos_nxt = (pos_inc >= PW'(w_eff)) ? '0 : pos_inc[IDX_W-1:0];
  assign wu_nxt  = (in_chan.probability < cutoff_r && wu_r != '0) ? wu_r - WU_W'(1) : wu_r;
  assign eval_now = (wu_nxt == '0) && (w_eff != '0);

  assign issue_go  = (state_r == ST_SCAN) && (issue_r < w_r);
  assign rd_addr   = issue_r[IDX_W-1:0];
  assign rd_entry  = pend_valid_r ? rd_data : '0;
  assign div_start = (state_r == ST_SCAN) && !issue_go && !pend_r;

  swkd_ram #(.WIDTH(PROB_W), .DEPTH(WINDOW_MAX)) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (pos_nxt),
    .wr_data (in_chan.probability),
    .rd_en   (issue_go),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  swkd_div #(.DEN_W(W_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num_hi   (sum_r[SUM_W-1:PROB_W]),
    .num_lo   (sum_r[PROB_W-1:0]),
    .den      (w_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = eval_now ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cutoff_r    <= CUTOFF_RST;
      wsize_r     <= WSIZE_RST;
      pos_r       <= '0;
      wu_r        <= WU_W'(WARMUP_WINDOWS);
      valid_r     <= '0;
      held_avg_r  <= '0;
      held_peak_r <= '0;
      best_r      <= '0;
      acc_r       <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid) begin
        if (cfg_chan.index == REG_CUTOFF) begin
          cutoff_r <= cfg_chan.data[CUTOFF_W-1:0];
        end else if (cfg_chan.index == REG_WINDOW_SIZE) begin
          wsize_r <= cfg_chan.data[WSIZE_W-1:0];
        end
      end
      pend_r <= issue_go;
      if (accept) begin
        acc_r            <= acc_r + TOTAL_W'(1);
        pos_r            <= pos_nxt;
        wu_r             <= wu_nxt;
        valid_r[pos_nxt] <= 1'b1;
      end
      if (state_r == ST_DIV && div_done) begin
        held_avg_r  <= quotient;
        held_peak_r <= peak_r;
        if (quotient > best_r) begin
          best_r <= quotient;
        end
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
        if (det_r) begin
          hit_r   <= hit_r + TOTAL_W'(1);
          valid_r <= '0;
          pos_r   <= '0;
          wu_r    <= WU_W'(WARMUP_WINDOWS);
        end
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      w_r     <= w_eff;
      thr_r   <= SUM_W'(cutoff_r) * SUM_W'(w_eff);
      sum_r   <= '0;
      peak_r  <= '0;
      issue_r <= '0;
      det_r   <= 1'b0;
      eval_r  <= 1'b0;
    end else begin
      if (issue_go) begin
        issue_r      <= issue_r + W_W'(1);
        pend_valid_r <= valid_r[rd_addr];
      end
      if (pend_r) begin
        sum_r <= sum_r + SUM_W'(rd_entry);
        if (rd_entry > peak_r) begin
          peak_r <= rd_entry;
        end
      end
      if (state_r == ST_DIV && div_done) begin
        eval_r <= 1'b1;
        det_r  <= (sum_r > thr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) begin
      out_chan.detected        <= det_r;
      out_chan.evaluated       <= eval_r;
      out_chan.window_average  <= held_avg_r;
      out_chan.window_peak     <= held_peak_r;
      out_chan.best_average    <= best_r;
      out_chan.inference_total <= acc_r;
      out_chan.detection_total <= hit_r + TOTAL_W'(det_r);
    end
  end

  assign out_chan.valid = out_valid_r;
endmodule

@@ hdl/swkd_checker.sv @@
// swkd_checker: port-level assertions for the keyword detector, bound to the
// top level; depends on swkd_pkg
module swkd_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   detected,
  input logic                   evaluated,
  input swkd_pkg::total_t       inference_total,
  input swkd_pkg::total_t       detection_total
);
  import swkd_pkg::*;

  logic   seen_r;
  total_t last_inf_r, last_det_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_inf_r <= inference_total;
      last_det_r <= detection_total;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(inference_total)
      && $stable(detection_total) && $stable(detected))
    else $error("result changed while stalled");

  a_det_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && detected |-> evaluated)
    else $error("detection without evaluation");

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_inf_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && seen_r |-> inference_total == last_inf_r + 32'd1)
    else $error("inference total skipped");

  a_det_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && seen_r
      |-> detection_total == last_det_r + {31'd0, detected})
    else $error("detection total out of step");
endmodule

bind sliding_window_keyword_detector swkd_checker u_swkd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .detected        (out_chan.detected),
  .evaluated       (out_chan.evaluated),
  .inference_total (out_chan.inference_total),
  .detection_total (out_chan.detection_total)
);

@@ tb/sv/sliding_window_keyword_detector_tb.sv @@
`timescale 1ns / 100ps
// sliding_window_keyword_detector_tb: self-checking bench with a directed table and
// random phases scored by a local window predictor; uses swkd_pkg, swkd_if and the dut
module sliding_window_keyword_detector_tb;
  import swkd_pkg::*;

  localparam int RING_DEPTH   = 16;
  localparam int WARMUP_LEN   = 100;
  localparam int RANDOM_ITEMS = 1110;
  localparam int CALM_AFTER   = 950;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;

  // index that maps to no register, must be ignored
  localparam cfg_idx_t REG_SPARE = cfg_idx_t'(8'hFE);

  typedef struct packed {
    logic   detected;
    logic   evaluated;
    prob_t  window_average;
    prob_t  window_peak;
    prob_t  best_average;
    total_t inference_total;
    total_t detection_total;
  } window_report_t;

  typedef enum logic {ROW_FEED, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    cfg_idx_t       index;   // ignored on feed rows
    logic [7:0]     value;
    int             count;
    bit             typed;
    window_report_t typed_report;
  } row_t;

  localparam window_report_t NO_REPORT = '0;
  localparam int PLAN_ROWS = 25;

  row_t plan [PLAN_ROWS] = '{
    '{ROW_FEED,  REG_CUTOFF,      8'h00, 1,   1'b1, '{1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 32'd1, 32'd0}},
    '{ROW_FEED,  REG_CUTOFF,      8'hFF, 1,   1'b1, '{1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 32'd2, 32'd0}},
    '{ROW_WRITE, REG_CUTOFF,      8'h00, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'h00, 1,   1'b1, '{1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 32'd3, 32'd0}},
    '{ROW_WRITE, REG_WINDOW_SIZE, 8'hE0, 1,   1'b0, NO_REPORT},
    '{ROW_WRITE, REG_CUTOFF,      8'hFF, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'h55, 99,  1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'hFE, 1,   1'b0, NO_REPORT},
    '{ROW_WRITE, REG_WINDOW_SIZE, 8'h3F, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'hFF, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'h80, 14,  1'b0, NO_REPORT},
    '{ROW_WRITE, REG_WINDOW_SIZE, 8'h04, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'h07, 1,   1'b0, NO_REPORT},
    '{ROW_WRITE, REG_WINDOW_SIZE, 8'h10, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'hC8, 1,   1'b0, NO_REPORT},
    '{ROW_WRITE, REG_WINDOW_SIZE, 8'h01, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'hFF, 2,   1'b0, NO_REPORT},
    '{ROW_WRITE, REG_CUTOFF,      8'h00, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'h01, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'h00, 1,   1'b0, NO_REPORT},
    '{ROW_WRITE, REG_CUTOFF,      8'h64, 1,   1'b0, NO_REPORT},
    '{ROW_WRITE, REG_WINDOW_SIZE, 8'hD0, 1,   1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'h63, 100, 1'b0, NO_REPORT},
    '{ROW_FEED,  REG_CUTOFF,      8'h96, 16,  1'b0, NO_REPORT},
    '{ROW_WRITE, REG_SPARE,       8'hA5, 1,   1'b0, NO_REPORT}
  };

  logic clk;
  logic rst_n;

  swkd_in_if  in_bus ();
  swkd_out_if out_bus ();
  swkd_cfg_if cfg_bus ();

  sliding_window_keyword_detector #(
    .WINDOW_MAX    (RING_DEPTH),
    .WARMUP_WINDOWS(WARMUP_LEN)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus),
    .cfg_chan(cfg_bus)
  );

  // predictor state
  logic [7:0]           cutoff_reg;
  logic [WSIZE_W-1:0]   window_reg;
  logic [7:0]           ring [RING_DEPTH];
  int unsigned          ring_pos;
  int                   warmup_left;
  prob_t                held_avg;
  prob_t                held_peak;
  prob_t                best_avg;
  total_t               seen_count;
  total_t               hit_count;

  window_report_t awaited_reports [$];

  bit gaps_on   = 1'b1;
  bit long_hold = 1'b0;
  int errors    = 0;
  int results_seen = 0;
  int evals_seen   = 0;
  int hits_seen    = 0;
  int fed_items    = 0;
  int cfg_writes   = 0;

  always begin
    #5 clk = ~clk;
  end

  function automatic window_report_t score_probability(prob_t p);
    window_report_t r;
    int unsigned w;
    int unsigned total;
    prob_t top;
    prob_t mean;
    r = '0;
    w = (window_reg > RING_DEPTH) ? RING_DEPTH : window_reg;
    seen_count++;
    ring_pos++;
    if (ring_pos >= w) ring_pos = 0;
    ring[ring_pos % RING_DEPTH] = p;
    if (p < cutoff_reg) begin
      warmup_left++;
      if (warmup_left > 0) warmup_left = 0;
    end
    if (warmup_left >= 0 && w != 0) begin
      total = 0;
      top = '0;
      for (int i = 0; i < w; i++) begin
        if (ring[i] > top) top = ring[i];
        total += ring[i];
      end
      mean = prob_t'(total / w);
      r.evaluated = 1'b1;
      held_avg  = mean;
      held_peak = top;
      if (mean > best_avg) best_avg = mean;
      if (total > cutoff_reg * w) begin
        r.detected = 1'b1;
        hit_count++;
        // detection restarts the window and the warm-up
        foreach (ring[i]) ring[i] = '0;
        ring_pos = 0;
        warmup_left = -WARMUP_LEN;
      end
    end
    r.window_average  = held_avg;
    r.window_peak     = held_peak;
    r.best_average    = best_avg;
    r.inference_total = seen_count;
    r.detection_total = hit_count;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic push_probability(prob_t p, bit typed, window_report_t typed_report);
    window_report_t r;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.probability = p;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    r = score_probability(p);
    awaited_reports.push_back(typed ? typed_report : r);
    fed_items++;
    @(negedge clk);
  endtask

  // registers only change with the block idle
  task automatic write_register(cfg_idx_t idx, logic [7:0] data);
    in_bus.valid = 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    if (idx == REG_CUTOFF) cutoff_reg = data;
    else if (idx == REG_WINDOW_SIZE) window_reg = data[WSIZE_W-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready = 1'b0;
      end else if (long_hold) begin
        long_hold = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_bus.ready = 1'b0;
      end else if (gaps_on && rst_n && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    window_report_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (out_bus.evaluated === 1'b1) evals_seen++;
      if (out_bus.detected === 1'b1) hits_seen++;
      if (awaited_reports.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        if (out_bus.detected !== want.detected) begin
          $error("detected: expected %0d, got %0d", want.detected, out_bus.detected);
          errors++;
        end
        if (out_bus.evaluated !== want.evaluated) begin
          $error("evaluated: expected %0d, got %0d", want.evaluated, out_bus.evaluated);
          errors++;
        end
        if (out_bus.window_average !== want.window_average) begin
          $error("window_average: expected %0d, got %0d",
                 want.window_average, out_bus.window_average);
          errors++;
        end
        if (out_bus.window_peak !== want.window_peak) begin
          $error("window_peak: expected %0d, got %0d", want.window_peak, out_bus.window_peak);
          errors++;
        end
        if (out_bus.best_average !== want.best_average) begin
          $error("best_average: expected %0d, got %0d",
                 want.best_average, out_bus.best_average);
          errors++;
        end
        if (out_bus.inference_total !== want.inference_total) begin
          $error("inference_total: expected %0d, got %0d",
                 want.inference_total, out_bus.inference_total);
          errors++;
        end
        if (out_bus.detection_total !== want.detection_total) begin
          $error("detection_total: expected %0d, got %0d",
                 want.detection_total, out_bus.detection_total);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("sliding_window_keyword_detector verification failed");
    $finish;
  end

  initial begin
    int fed_random;
    int len;
    int roll;
    logic [7:0] cut;
    logic [WSIZE_W-1:0] wsel;
    prob_t p;
    clk = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.probability = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_CUTOFF;
    cfg_bus.data = '0;
    cutoff_reg = CUTOFF_RST;
    window_reg = WSIZE_RST;
    foreach (ring[i]) ring[i] = '0;
    ring_pos = 0;
    warmup_left = -WARMUP_LEN;
    held_avg = '0;
    held_peak = '0;
    best_avg = '0;
    seen_count = '0;
    hit_count = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        write_register(plan[r].index, plan[r].value);
      end else begin
        for (int c = 0; c < plan[r].count; c++)
          push_probability(plan[r].value, plan[r].typed, plan[r].typed_report);
      end
    end

    // random phases: mostly warm-up runs below cutoff, then bursts above it
    fed_random = 0;
    while (fed_random < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) cut = 8'h00;
      else if (roll == 1) cut = 8'hFF;
      else if (roll == 2) cut = 8'($urandom_range(0, 255));
      else cut = 8'($urandom_range(40, 220));
      write_register(REG_CUTOFF, cut);
      roll = $urandom_range(0, 9);
      if (roll == 0) wsel = '0;
      else if (roll == 1) wsel = WSIZE_W'($urandom_range(17, 31));
      else wsel = WSIZE_W'($urandom_range(1, 16));
      write_register(REG_WINDOW_SIZE, {3'($urandom_range(0, 7)), wsel});
      len = $urandom_range(40, 160);
      for (int i = 0; i < len && fed_random < RANDOM_ITEMS; i++) begin
        if (warmup_left < 0) begin
          if (cutoff_reg != 0 && $urandom_range(0, 19) != 0)
            p = prob_t'($urandom_range(0, cutoff_reg - 1));
          else
            p = prob_t'($urandom_range(0, 255));
        end else if ($urandom_range(0, 9) < 6) begin
          p = prob_t'($urandom_range(cutoff_reg, 255));
        end else begin
          p = prob_t'($urandom_range(0, 255));
        end
        if (fed_random == HOLD_AT) long_hold = 1'b1;
        if (fed_random == CALM_AFTER) gaps_on = 1'b0;
        push_probability(p, 1'b0, NO_REPORT);
        fed_random++;
      end
    end
    in_bus.valid = 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("fed %0d probabilities over %0d register writes; %0d results checked",
             fed_items, cfg_writes, results_seen);
    $display("window evaluations %0d, detections %0d", evals_seen, hits_seen);
    if (errors == 0) begin
      $display("sliding_window_keyword_detector verification clean");
    end else begin
      $display("sliding_window_keyword_detector verification failed");
    end
    $finish;
  end

endmodule
